[rtl/lpas_pkg.sv]
// Package for the line pixel-at-step block: widths, transaction payload types
// and the divider pipeline record passed from setup to the output stage. No dependencies.
package lpas_pkg;

    // Coordinate width of endpoints and pixels
    localparam int COORD_BITS = 12;
    // Fixed field widths
    localparam int STEP_BITS  = 12;
    localparam int COLOR_BITS = 32;

    // Signed delta and lengthened magnitude width
    localparam int DELTA_BITS = COORD_BITS + 1;
    // step * lengthened |minor delta|
    localparam int PROD_BITS  = STEP_BITS + DELTA_BITS;
    // Width for coordinate sums and step/span compares
    localparam int SUM_BITS   = (COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS;

    // Divider: quotient bits resolved per pipeline stage
    localparam int QBITS_PER_STAGE = 3;
    localparam int DIV_STAGES      = STEP_BITS / QBITS_PER_STAGE;

    // Line request transaction
    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic        [COLOR_BITS-1:0] pixel_color;
        logic        [STEP_BITS-1:0]  step_index;
    } line_t;

    // Pixel result transaction
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic        [COLOR_BITS-1:0] color_out;
        logic                         on_line;
        logic                         last_pixel;
    } pixel_t;

    // Record carried through the divider stages
    typedef struct packed {
        logic [COORD_BITS-1:0] a0;       // major start after swap
        logic [COORD_BITS-1:0] b0;       // minor start after swap
        logic                  x_major;
        logic                  dir_neg;  // minor coordinate falls
        logic [STEP_BITS-1:0]  step;
        logic [COLOR_BITS-1:0] color;
        logic                  on;
        logic                  last;
        logic [DELTA_BITS-1:0] rem;      // partial remainder
        logic [STEP_BITS-1:0]  dvd_low;  // dividend bits not yet consumed
        logic [STEP_BITS-1:0]  quo;      // quotient bits so far
        logic [DELTA_BITS-1:0] divisor;  // lengthened |major delta|, never zero
    } div_t;

endpackage

[rtl/lpas_setup.sv]
// Front two pipeline stages: endpoint deltas, major axis pick, swap, span
// compare and the step * lengthened |minor delta| product. Depends on lpas_pkg.
module lpas_setup (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  lpas_pkg::line_t up_data,
    output logic           dn_valid,
    input  logic           dn_ready,
    output lpas_pkg::div_t dn_data
);
    import lpas_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic [COLOR_BITS-1:0] color;
        logic [STEP_BITS-1:0]  step;
        logic [COORD_BITS-1:0] abs_dx;
        logic [COORD_BITS-1:0] abs_dy;
        logic                  dx_neg;
        logic                  dy_neg;
    } geo_t;

    logic            s1_valid_reg;
    geo_t            s1_reg;
    geo_t            s1_next;
    logic            s1_ready;
    logic            s2_valid_reg;
    div_t            s2_reg;
    div_t            s2_next;
    logic            s2_ready;

    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
    logic        [DELTA_BITS-1:0] mag_x;
    logic        [DELTA_BITS-1:0] mag_y;

    logic [DELTA_BITS-1:0] len_x;
    logic [DELTA_BITS-1:0] len_y;
    logic [DELTA_BITS-1:0] len_maj;
    logic [DELTA_BITS-1:0] len_min;
    logic                  x_major;
    logic                  maj_neg;
    logic                  min_neg;
    logic [COORD_BITS-1:0] min_abs;
    logic [COORD_BITS-1:0] span;
    logic [COORD_BITS-1:0] start_maj;
    logic [COORD_BITS-1:0] end_maj;
    logic [COORD_BITS-1:0] start_min;
    logic [COORD_BITS-1:0] end_min;
    logic [PROD_BITS-1:0]  prod;

    // Stage 1: signed deltas and their magnitudes
    always_comb
    begin
        dx = DELTA_BITS'(up_data.end_x) - DELTA_BITS'(up_data.start_x);
        dy = DELTA_BITS'(up_data.end_y) - DELTA_BITS'(up_data.start_y);
        mag_x = dx[DELTA_BITS-1] ? DELTA_BITS'(-dx) : DELTA_BITS'(dx);
        mag_y = dy[DELTA_BITS-1] ? DELTA_BITS'(-dy) : DELTA_BITS'(dy);
        s1_next.sx     = up_data.start_x;
        s1_next.sy     = up_data.start_y;
        s1_next.ex     = up_data.end_x;
        s1_next.ey     = up_data.end_y;
        s1_next.color  = up_data.pixel_color;
        s1_next.step   = up_data.step_index;
        s1_next.abs_dx = mag_x[COORD_BITS-1:0];
        s1_next.abs_dy = mag_y[COORD_BITS-1:0];
        s1_next.dx_neg = dx[DELTA_BITS-1];
        s1_next.dy_neg = dy[DELTA_BITS-1];
    end

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
            s1_reg <= s1_next;
    end

    // Stage 2: lengthened deltas, axis pick, swap, span test, product
    always_comb
    begin
        len_x = DELTA_BITS'(s1_reg.abs_dx) + DELTA_BITS'(s1_reg.abs_dx != '0);
        len_y = DELTA_BITS'(s1_reg.abs_dy) + DELTA_BITS'(s1_reg.abs_dy != '0);
        x_major   = len_x >= len_y;
        len_maj   = x_major ? len_x : len_y;
        len_min   = x_major ? len_y : len_x;
        maj_neg   = x_major ? s1_reg.dx_neg : s1_reg.dy_neg;
        min_neg   = x_major ? s1_reg.dy_neg : s1_reg.dx_neg;
        min_abs   = x_major ? s1_reg.abs_dy : s1_reg.abs_dx;
        span      = x_major ? s1_reg.abs_dx : s1_reg.abs_dy;
        start_maj = x_major ? s1_reg.sx : s1_reg.sy;
        end_maj   = x_major ? s1_reg.ex : s1_reg.ey;
        start_min = x_major ? s1_reg.sy : s1_reg.sx;
        end_min   = x_major ? s1_reg.ey : s1_reg.ex;
        prod      = PROD_BITS'(s1_reg.step) * PROD_BITS'(len_min);

        s2_next.a0      = maj_neg ? end_maj : start_maj;
        s2_next.b0      = maj_neg ? end_min : start_min;
        s2_next.x_major = x_major;
        // after a swap the minor run is reversed
        s2_next.dir_neg = maj_neg ? (!min_neg && (min_abs != '0)) : min_neg;
        s2_next.step    = s1_reg.step;
        s2_next.color   = s1_reg.color;
        s2_next.on      = SUM_BITS'(s1_reg.step) <= SUM_BITS'(span);
        s2_next.last    = SUM_BITS'(s1_reg.step) == SUM_BITS'(span);
        s2_next.rem     = prod[PROD_BITS-1:STEP_BITS];
        s2_next.dvd_low = prod[STEP_BITS-1:0];
        s2_next.quo     = '0;
        // lone dot: product is zero, a unit divisor keeps the quotient zero
        s2_next.divisor = (len_maj == '0) ? DELTA_BITS'(1) : len_maj;
    end

    assign s2_ready = !s2_valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_reg;

endmodule

[rtl/lpas_div_stage.sv]
// One divider pipeline stage: resolves QBITS_PER_STAGE quotient bits of
// step * lengthened |minor| / lengthened |major| by restoring division. Depends on lpas_pkg.
module lpas_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  lpas_pkg::div_t up_data,
    output logic           dn_valid,
    input  logic           dn_ready,
    output lpas_pkg::div_t dn_data
);
    import lpas_pkg::*;

    logic valid_reg;
    div_t data_reg;
    div_t data_next;
    logic [DELTA_BITS:0] trial;

    // Shift in one dividend bit per step, subtract when it fits
    always_comb
    begin
        data_next = up_data;
        trial     = '0;
        for (int k = 0; k < QBITS_PER_STAGE; k++)
        begin
            trial = {data_next.rem, data_next.dvd_low[STEP_BITS-1]};
            data_next.dvd_low = {data_next.dvd_low[STEP_BITS-2:0], 1'b0};
            if (trial >= {1'b0, data_next.divisor})
            begin
                trial = trial - {1'b0, data_next.divisor};
                data_next.quo = {data_next.quo[STEP_BITS-2:0], 1'b1};
            end
            else
            begin
                data_next.quo = {data_next.quo[STEP_BITS-2:0], 1'b0};
            end
            data_next.rem = trial[DELTA_BITS-1:0];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

`ifndef SYNTHESIS
    // remainder always stays below the divisor
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem < data_reg.divisor))
        else $error("divider remainder not below divisor");

    // minor delta never exceeds major delta, so the quotient is bounded by step
    a_quo_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.quo <= data_reg.step))
        else $error("partial quotient exceeds step");
`endif

endmodule

[rtl/lpas_compose.sv]
// Output stage: adds step to the major start and the signed quotient to the
// minor start, maps back to x/y and registers the pixel. Depends on lpas_pkg.
module lpas_compose (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  lpas_pkg::div_t  up_data,
    output logic            dn_valid,
    input  logic            dn_ready,
    output lpas_pkg::pixel_t dn_data
);
    import lpas_pkg::*;

    logic   valid_reg;
    pixel_t data_reg;
    pixel_t data_next;
    logic [SUM_BITS-1:0]   major_w;
    logic [SUM_BITS-1:0]   minor_w;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;

    // Pixel coordinates; steps past the end give a zero pixel
    always_comb
    begin
        major_w = SUM_BITS'(up_data.a0) + SUM_BITS'(up_data.step);
        minor_w = up_data.dir_neg ? (SUM_BITS'(up_data.b0) - SUM_BITS'(up_data.quo))
                                  : (SUM_BITS'(up_data.b0) + SUM_BITS'(up_data.quo));
        major = major_w[COORD_BITS-1:0];
        minor = minor_w[COORD_BITS-1:0];
        data_next.color_out  = up_data.color;
        data_next.on_line    = up_data.on;
        data_next.last_pixel = up_data.on && up_data.last;
        if (!up_data.on)
        begin
            data_next.pixel_x = '0;
            data_next.pixel_y = '0;
        end
        else if (up_data.x_major)
        begin
            data_next.pixel_x = major;
            data_next.pixel_y = minor;
        end
        else
        begin
            data_next.pixel_x = minor;
            data_next.pixel_y = major;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[rtl/line_pixel_at_step.sv]
// Line pixel-at-step top level: setup stages, divider pipeline, output stage.
// Depends on lpas_pkg, lpas_setup, lpas_div_stage and lpas_compose.
//
// Usage:
//   line channel (line_valid/line_ready/line) carries one request transaction:
//   both endpoints, a color word and a step index along the major axis.
//   pixel channel (pixel_valid/pixel_ready/pixel) returns one pixel per
//   request, in order: coordinates, the color, on_line and last_pixel.
//   Steps beyond the major span come back with on_line low and a zero pixel.
// Stages: 2 setup stages + 4 divider stages + 1 output stage = 7 registers, passed in that order.
// Throughput: one transaction per clock while pixel_ready is high; every stage holds one transaction
//   and the quotient is resolved three bits per divider stage.
// Reset: rst_n clears all stage valid bits; the pipeline comes up empty with
//   line_ready high.
// Stall: when pixel_ready is low the output holds; upstream stages keep
//   filling bubbles, and line_ready drops only once every stage is full.
module line_pixel_at_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             line_valid,
    output logic             line_ready,
    input  lpas_pkg::line_t  line,
    output logic             pixel_valid,
    input  logic             pixel_ready,
    output lpas_pkg::pixel_t pixel
);
    import lpas_pkg::*;

    logic stg_valid [DIV_STAGES+1];
    logic stg_ready [DIV_STAGES+1];
    div_t stg_data  [DIV_STAGES+1];

    // Geometry and product
    lpas_setup u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (line_valid),
        .up_ready (line_ready),
        .up_data  (line),
        .dn_valid (stg_valid[0]),
        .dn_ready (stg_ready[0]),
        .dn_data  (stg_data[0])
    );

    // Divider pipeline
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        lpas_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[i]),
            .up_ready (stg_ready[i]),
            .up_data  (stg_data[i]),
            .dn_valid (stg_valid[i+1]),
            .dn_ready (stg_ready[i+1]),
            .dn_data  (stg_data[i+1])
        );
    end

    // Final pixel
    lpas_compose u_compose (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stg_valid[DIV_STAGES]),
        .up_ready (stg_ready[DIV_STAGES]),
        .up_data  (stg_data[DIV_STAGES]),
        .dn_valid (pixel_valid),
        .dn_ready (pixel_ready),
        .dn_data  (pixel)
    );

`ifndef SYNTHESIS
    // an empty output register lets the whole pipeline advance
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_valid |-> line_ready)
        else $error("line_ready low with empty output");

    // the final pixel is always on the line
    a_last_on_line: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel.last_pixel) |-> pixel.on_line)
        else $error("last_pixel set off the line");

    // off-line steps return a zero pixel
    a_off_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel.on_line) |-> ((pixel.pixel_x == '0) && (pixel.pixel_y == '0)))
        else $error("off-line pixel not zero");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Testbench for line_pixel_at_step. Drives line request transactions and checks
// pixel transactions against an in-bench integer rasterizer. Depends on lpas_pkg.
module testbench;
    import lpas_pkg::*;

    localparam int RANDOM_LINES  = 1000;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int HOLD_CYCLES   = 80;
    localparam int BURST_LINES   = 40;
    localparam int SETTLE_CYCLES = 20;

    // Directed row: request plus a hand-written pixel where `typed` is set
    typedef struct packed {
        line_t  req;
        logic   typed;
        pixel_t want;
    } line_row_t;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   line_valid  = 1'b0;
    line_t  line_req    = '0;
    logic   pixel_ready = 1'b0;
    logic   line_ready;
    logic   pixel_valid;
    pixel_t pixel_out;

    pixel_t    pending_pixels[$];
    line_row_t directed_rows[$];
    int        mismatch_count  = 0;
    int        lines_sent      = 0;
    int        cycle_count     = 0;
    bit        hold_off_request = 1'b0;
    bit        hold_active      = 1'b0;

    line_pixel_at_step dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_valid  (line_valid),
        .line_ready  (line_ready),
        .line        (line_req),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel_out)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Reset held low from time zero, then released once
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d pixels pending",
                     cycle_count, pending_pixels.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int abs_of(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int sign_of(int v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Integer rasterizer: pixel at the requested step of the line
    function automatic pixel_t predict_pixel(line_t req);
        int     sx, sy, ex, ey, step;
        int     ldx, ldy, lmaj, lmin;
        int     a0, a1, b0, b1, tmp;
        int     span, quo, dir, px, py;
        bit     x_major, on;
        pixel_t p;
        sx   = int'($signed(req.start_x));
        sy   = int'($signed(req.start_y));
        ex   = int'($signed(req.end_x));
        ey   = int'($signed(req.end_y));
        step = int'(req.step_index);
        // deltas grow by one pixel away from zero
        ldx  = (ex - sx) + sign_of(ex - sx);
        ldy  = (ey - sy) + sign_of(ey - sy);
        x_major = abs_of(ldx) >= abs_of(ldy);
        if (x_major)
        begin
            a0 = sx; a1 = ex; b0 = sy; b1 = ey; lmaj = ldx; lmin = ldy;
        end
        else
        begin
            a0 = sy; a1 = ey; b0 = sx; b1 = ex; lmaj = ldy; lmin = ldx;
        end
        // major coordinate must rise from the start
        if (lmaj < 0)
        begin
            tmp = a0; a0 = a1; a1 = tmp;
            tmp = b0; b0 = b1; b1 = tmp;
        end
        span = a1 - a0;
        on   = step <= span;
        px   = 0;
        py   = 0;
        if (on)
        begin
            quo = (lmaj != 0) ? (step * abs_of(lmin)) / abs_of(lmaj) : 0;
            dir = (b1 >= b0) ? 1 : -1;
            if (x_major)
            begin
                px = a0 + step; py = b0 + dir * quo;
            end
            else
            begin
                px = b0 + dir * quo; py = a0 + step;
            end
        end
        p.pixel_x    = px[COORD_BITS-1:0];
        p.pixel_y    = py[COORD_BITS-1:0];
        p.color_out  = req.pixel_color;
        p.on_line    = on;
        p.last_pixel = on && (step == span);
        return p;
    endfunction

    function automatic line_t mk_line(int sx, int sy, int ex, int ey,
                                      logic [COLOR_BITS-1:0] color, int step);
        line_t l;
        l.start_x     = sx[COORD_BITS-1:0];
        l.start_y     = sy[COORD_BITS-1:0];
        l.end_x       = ex[COORD_BITS-1:0];
        l.end_y       = ey[COORD_BITS-1:0];
        l.pixel_color = color;
        l.step_index  = step[STEP_BITS-1:0];
        return l;
    endfunction

    function automatic pixel_t mk_pixel(int px, int py, logic [COLOR_BITS-1:0] color,
                                        bit on, bit last);
        pixel_t p;
        p.pixel_x    = px[COORD_BITS-1:0];
        p.pixel_y    = py[COORD_BITS-1:0];
        p.color_out  = color;
        p.on_line    = on;
        p.last_pixel = last;
        return p;
    endfunction

    // Major span as the larger coordinate distance
    function automatic int span_of(line_t l);
        int dx, dy;
        dx = abs_of(int'($signed(l.end_x)) - int'($signed(l.start_x)));
        dy = abs_of(int'($signed(l.end_y)) - int'($signed(l.start_y)));
        return (dx > dy) ? dx : dy;
    endfunction

    // Mostly on the line, some at the ends, some past them
    function automatic int pick_step(int sp);
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5)
            return $urandom_range(0, sp);
        else if (r == 6)
            return sp;
        else if (r == 7)
            return 0;
        else if (r == 8)
            return (sp < 4095) ? sp + 1 : sp;
        else
            return $urandom_range(0, 4095);
    endfunction

    // Short line around a random origin, used for step-by-step walks
    function automatic line_t short_line();
        int sx, sy;
        sx = int'($signed(12'($urandom_range(0, 4095))));
        sy = int'($signed(12'($urandom_range(0, 4095))));
        return mk_line(sx, sy,
                       sx + int'($urandom_range(0, 40)) - 20,
                       sy + int'($urandom_range(0, 40)) - 20,
                       $urandom, 0);
    endfunction

    // Random request: horizontal, vertical, diagonal, dot, short or arbitrary
    function automatic line_t random_line();
        int    sx, sy, d, kind;
        line_t l;
        sx   = int'($signed(12'($urandom_range(0, 4095))));
        sy   = int'($signed(12'($urandom_range(0, 4095))));
        d    = int'($urandom_range(0, 4095)) - 2048;
        kind = $urandom_range(0, 9);
        case (kind)
            0: l = mk_line(sx, sy, sx + d, sy, $urandom, 0);
            1: l = mk_line(sx, sy, sx, sy + d, $urandom, 0);
            2: l = mk_line(sx, sy, sx + d, ($urandom_range(0, 1) != 0) ? sy + d : sy - d,
                           $urandom, 0);
            3: l = mk_line(sx, sy, sx, sy, $urandom, 0);
            4, 5: l = short_line();
            default: l = mk_line(sx, sy, $urandom_range(0, 4095), $urandom_range(0, 4095),
                                 $urandom, 0);
        endcase
        l.step_index = STEP_BITS'(pick_step(span_of(l)));
        return l;
    endfunction

    // Sender idle: mostly none, some short, a few long
    function automatic int line_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Append one row to the directed table
    task automatic add_row(line_row_t row);
        directed_rows = {directed_rows, row};
    endtask

    // Offer one transaction and wait for it to be taken; called at a rising edge
    task automatic send_line(line_t req, pixel_t want);
        line_valid <= 1'b1;
        line_req   <= req;
        do
            @(posedge clk);
        while (!line_ready);
        pending_pixels = {pending_pixels, want};
        lines_sent++;
    endtask

    task automatic idle_line(int n);
        if (n > 0)
        begin
            line_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_pixels();
        line_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Receiver holds off while a back-to-back burst piles up in the pipeline;
    // called right after a drain, with the sender already idle
    task automatic burst_under_hold();
        line_t req;
        hold_off_request = 1'b1;
        while (!hold_active)
            @(posedge clk);
        repeat (BURST_LINES)
        begin
            req = random_line();
            send_line(req, predict_pixel(req));
        end
    endtask

    // Pixel checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pixel_valid && pixel_ready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("pixel with none pending, pixel_x", pixel_out.pixel_x, 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_out.pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", pixel_out.pixel_x, want.pixel_x);
                if (pixel_out.pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", pixel_out.pixel_y, want.pixel_y);
                if (pixel_out.color_out !== want.color_out)
                    report_mismatch("color_out", pixel_out.color_out, want.color_out);
                if (pixel_out.on_line !== want.on_line)
                    report_mismatch("on_line", pixel_out.on_line, want.on_line);
                if (pixel_out.last_pixel !== want.last_pixel)
                    report_mismatch("last_pixel", pixel_out.last_pixel, want.last_pixel);
            end
        end
    end

    // Receiver: ready stretches and stalls, plus the requested long hold-off
    initial
    begin
        int r, on_len, off_len;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            r      = $urandom_range(0, 99);
            on_len = (r < 20) ? $urandom_range(30, 120) : $urandom_range(1, 15);
            pixel_ready <= 1'b1;
            repeat (on_len) @(posedge clk);
            if (hold_off_request)
            begin
                hold_active = 1'b1;
                pixel_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active      = 1'b0;
                hold_off_request = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    off_len = 0;
                else if (r < 85)
                    off_len = $urandom_range(1, 3);
                else if (r < 97)
                    off_len = $urandom_range(4, 10);
                else
                    off_len = $urandom_range(20, 60);
                if (off_len > 0)
                begin
                    pixel_ready <= 1'b0;
                    repeat (off_len) @(posedge clk);
                end
            end
        end
    end

    // Sender: directed rows, held bursts, then random lines and step-by-step walks
    initial
    begin
        line_row_t row;
        line_t     req;
        int        sp;
        bit        mid_done;
        mid_done = 1'b0;

        // lone dots, full-range extremes, steps past the end
        add_row('{mk_line(0, 0, 0, 0, 32'h0, 0), 1'b1,
                  mk_pixel(0, 0, 32'h0, 1, 1)});
        add_row('{mk_line(0, 0, 0, 0, 32'hFFFF_FFFF, 1), 1'b1,
                  mk_pixel(0, 0, 32'hFFFF_FFFF, 0, 0)});
        add_row('{mk_line(-2048, 2047, -2048, 2047, 32'h1234_5678, 0), 1'b1,
                  mk_pixel(-2048, 2047, 32'h1234_5678, 1, 1)});
        add_row('{mk_line(-2048, -2048, 2047, 2047, 32'hFFFF_FFFF, 0), 1'b1,
                  mk_pixel(-2048, -2048, 32'hFFFF_FFFF, 1, 0)});
        add_row('{mk_line(-2048, -2048, 2047, 2047, 32'h0, 4095), 1'b1,
                  mk_pixel(2047, 2047, 32'h0, 1, 1)});
        add_row('{mk_line(2047, 2047, -2048, -2048, 32'h5A5A_A5A5, 0), 1'b1,
                  mk_pixel(-2048, -2048, 32'h5A5A_A5A5, 1, 0)});
        add_row('{mk_line(-2048, 0, 2047, 0, 32'h0000_FFFF, 4095), 1'b1,
                  mk_pixel(2047, 0, 32'h0000_FFFF, 1, 1)});
        add_row('{mk_line(5, 2047, 5, -2048, 32'hFFFF_0000, 0), 1'b1,
                  mk_pixel(5, -2048, 32'hFFFF_0000, 1, 0)});
        add_row('{mk_line(0, 0, 3, 0, 32'hCAFE_0001, 4095), 1'b1,
                  mk_pixel(0, 0, 32'hCAFE_0001, 0, 0)});
        add_row('{mk_line(0, 0, 3, 0, 32'hCAFE_0002, 4), 1'b1,
                  mk_pixel(0, 0, 32'hCAFE_0002, 0, 0)});
        // ties, steep and shallow lines in every direction
        add_row('{mk_line(0, 0, 5, 5, 32'h1, 2), 1'b0, '0});
        add_row('{mk_line(0, 0, -5, 5, 32'h2, 3), 1'b0, '0});
        add_row('{mk_line(0, 0, 2, 9, 32'h3, 4), 1'b0, '0});
        add_row('{mk_line(10, 10, 7, -20, 32'h4, 11), 1'b0, '0});
        add_row('{mk_line(-100, 50, 300, -7, 32'h5, 123), 1'b0, '0});
        add_row('{mk_line(100, -3, -50, 20, 32'h6, 150), 1'b0, '0});
        add_row('{mk_line(0, 0, 1, 0, 32'h7, 1), 1'b0, '0});
        add_row('{mk_line(7, 7, 7, 8, 32'h8, 0), 1'b0, '0});
        add_row('{mk_line(-1, -1, 0, -2048, 32'h9, 2047), 1'b0, '0});
        add_row('{mk_line(2047, -2048, -2048, 2047, 32'hA, 2000), 1'b0, '0});
        add_row('{mk_line(2047, 0, 0, 1, 32'hA5A5_5A5A, 1000), 1'b0, '0});
        add_row('{mk_line(3, -7, -900, 1500, 32'h8000_0000, 3547), 1'b0, '0});

        wait (rst_n);
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_line(row.req, row.typed ? row.want : predict_pixel(row.req));
            idle_line(line_gap());
        end

        // quiet pipeline, then a burst against a stalled receiver
        drain_pixels();
        burst_under_hold();

        lines_sent = 0;
        while (lines_sent < RANDOM_LINES)
        begin
            if (!mid_done && lines_sent >= RANDOM_LINES / 2)
            begin
                drain_pixels();
                burst_under_hold();
                mid_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 4)
            begin
                // walk a short line from its first pixel to one past the end
                req = short_line();
                sp  = span_of(req);
                for (int s = 0; s <= sp + 1; s++)
                begin
                    req.step_index = s[STEP_BITS-1:0];
                    send_line(req, predict_pixel(req));
                    idle_line(line_gap());
                end
            end
            else
            begin
                req = random_line();
                send_line(req, predict_pixel(req));
                idle_line(line_gap());
            end
        end

        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
